[rtl/core/bpa_pkg.sv]
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Shared types, codes and default parameter values for the allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

  // Default sizing of the frame pool.
  localparam int unsigned DefFrameCount = 1024;
  localparam int unsigned DefTopOrder   = 6;
  localparam int unsigned DefPageShift  = 12;

  // Width of an order value as it travels on the ports.
  localparam int unsigned OrderW = 4;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
  localparam logic [1:0] STATUS_BAD_ORDER = 2'd2;

  // Request payload.
  typedef struct packed {
    logic              req_type;
    logic [OrderW-1:0] block_order;
    logic [31:0]       block_address;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } res_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_POP,
    S_SPLIT,
    S_MERGE,
    S_MARK_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_CLR_F,
    S_CLR_M,
    S_PUSH
  } state_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_ALLOC_RD,
    OP_ALLOC_POP,
    OP_SPLIT,
    OP_MARK_RD,
    OP_WALK_START,
    OP_WALK_RD,
    OP_WALK_CHK,
    OP_CLR_F,
    OP_CLR_M,
    OP_PUSH,
    OP_RES_GRANT,
    OP_RES_NOMEM,
    OP_RES_ORDER
  } dp_op_e;

  // Controller to datapath.
  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic init_last;
    logic bad_order;
    logic is_free;
    logic alloc_found;
    logic out_range;
    logic split_more;
    logic merge_ok;
    logic mark_match;
    logic walk_live;
    logic walk_hit;
  } dp_status_t;

endpackage

[rtl/core/bpa_ctrl.sv]
// ---------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences the initialisation sweep, the allocation split and the free merge.
// ---------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bpa_pkg::dp_status_t status_i,
  output bpa_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (status_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status_i.bad_order) begin
          state_d = S_IDLE;
        end else if (!status_i.is_free) begin
          state_d = status_i.alloc_found ? S_ALLOC_POP : S_IDLE;
        end else begin
          state_d = status_i.out_range ? S_IDLE : S_MERGE;
        end
      end
      S_ALLOC_POP: state_d = S_SPLIT;
      S_SPLIT: begin
        if (!status_i.split_more) state_d = S_IDLE;
      end
      S_MERGE: state_d = status_i.merge_ok ? S_MARK_CHK : S_PUSH;
      S_MARK_CHK: state_d = status_i.mark_match ? S_WALK_RD : S_PUSH;
      S_WALK_RD: state_d = status_i.walk_live ? S_WALK_CHK : S_PUSH;
      S_WALK_CHK: state_d = status_i.walk_hit ? S_CLR_F : S_WALK_RD;
      S_CLR_F: state_d = S_CLR_M;
      S_CLR_M: state_d = S_MERGE;
      S_PUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath command for the current cycle.
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_INIT: cmd_o.op = OP_INIT;
      S_IDLE: begin
        if (start_i) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH: begin
        if (status_i.bad_order) begin
          cmd_o.op = OP_RES_ORDER;
        end else if (!status_i.is_free) begin
          cmd_o.op = status_i.alloc_found ? OP_ALLOC_RD : OP_RES_NOMEM;
        end else if (status_i.out_range) begin
          // A free outside the pool only reports an ordinary result.
          cmd_o.op = OP_RES_GRANT;
        end
      end
      S_ALLOC_POP: cmd_o.op = OP_ALLOC_POP;
      S_SPLIT: cmd_o.op = status_i.split_more ? OP_SPLIT : OP_RES_GRANT;
      S_MERGE: begin
        if (status_i.merge_ok) cmd_o.op = OP_MARK_RD;
      end
      S_MARK_CHK: begin
        if (status_i.mark_match) cmd_o.op = OP_WALK_START;
      end
      S_WALK_RD: begin
        if (status_i.walk_live) cmd_o.op = OP_WALK_RD;
      end
      S_WALK_CHK: cmd_o.op = OP_WALK_CHK;
      S_CLR_F: cmd_o.op = OP_CLR_F;
      S_CLR_M: cmd_o.op = OP_CLR_M;
      S_PUSH: cmd_o.op = OP_PUSH;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[rtl/core/bpa_datapath.sv]
// ---------------------------------------------------------------------------
// Buddy page allocator datapath
// Frame tables, list heads, walk registers and the result register.
// ---------------------------------------------------------------------------
module bpa_datapath #(
  parameter int unsigned FRAME_COUNT = bpa_pkg::DefFrameCount,
  parameter int unsigned TOP_ORDER   = bpa_pkg::DefTopOrder,
  parameter int unsigned PAGE_SHIFT  = bpa_pkg::DefPageShift
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpa_pkg::dp_cmd_t    cmd_i,
  input  bpa_pkg::req_t       req_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output bpa_pkg::dp_status_t status_o,
  output logic                done_o,
  output bpa_pkg::res_t       result_o
);
  import bpa_pkg::*;

  localparam int unsigned ListCount = TOP_ORDER + 1;
  localparam int unsigned IW        = $clog2(FRAME_COUNT);
  localparam int unsigned FW        = $clog2(FRAME_COUNT + 1);
  localparam int unsigned MW        = $clog2(TOP_ORDER + 2);
  localparam int unsigned LW        = (ListCount > 1) ? $clog2(ListCount) : 1;
  localparam int unsigned SW        = $clog2(FRAME_COUNT + 2);
  localparam int unsigned Span      = 1 << TOP_ORDER;
  localparam int unsigned TopHead   = (FRAME_COUNT >= Span) ?
                                      ((FRAME_COUNT / Span) - 1) * Span : FRAME_COUNT;
  localparam logic [FW-1:0] Nil     = FW'(FRAME_COUNT);

  // Frame tables.
  logic [MW-1:0] mark_mem [FRAME_COUNT];
  logic [FW-1:0] next_mem [FRAME_COUNT];
  logic          mark_we, next_we;
  logic [IW-1:0] mark_wa, mark_ra, next_wa, next_ra;
  logic [MW-1:0] mark_wd, mark_rd_q;
  logic [FW-1:0] next_wd, next_rd_q;

  // Control and working registers.
  logic [FW-1:0]     head_q [ListCount];
  logic [IW-1:0]     init_cnt_q;
  logic [31:0]       base_q;
  logic              res_valid_q;
  res_t              res_q;
  logic              is_free_q, bad_order_q, found_q, out_range_q;
  logic [OrderW-1:0] lvl_q, cur_q;
  logic [FW-1:0]     f_q, walk_q, prev_q;
  logic [SW-1:0]     steps_q;

  // Request decode at load time.
  logic [31:0]       off, fwide, fmask;
  logic [32:0]       fend;
  logic              ld_out_range, src_found;
  logic [OrderW-1:0] src_sel;

  // Derived working values.
  logic [31:0]       mate32, ic32, split32;
  logic [IW-1:0]     mate_ix, f_ix;
  logic [OrderW-1:0] cur_m1, cur_p1;
  logic [LW-1:0]     cur_l, cur_m1_l, src_l;
  logic              init_head;
  logic [MW-1:0]     init_mark;
  logic [FW-1:0]     init_next;

  // Free frame number, rounded down to the order, and its range check.
  always_comb begin
    off          = req_i.block_address - base_q;
    fwide        = off >> PAGE_SHIFT;
    fmask        = fwide & ~((32'd1 << req_i.block_order) - 32'd1);
    fend         = {1'b0, fmask} + (33'd1 << req_i.block_order);
    ld_out_range = (fend > 33'(FRAME_COUNT));
  end

  // Lowest non-empty list at or above the requested order.
  always_comb begin
    src_found = 1'b0;
    src_sel   = '0;
    for (int j = ListCount - 1; j >= 0; j--) begin
      if ((OrderW'(j) >= req_i.block_order) && (head_q[j] < Nil)) begin
        src_found = 1'b1;
        src_sel   = OrderW'(j);
      end
    end
  end

  always_comb begin
    cur_m1   = cur_q - OrderW'(1);
    cur_p1   = cur_q + OrderW'(1);
    cur_l    = cur_q[LW-1:0];
    cur_m1_l = cur_m1[LW-1:0];
    src_l    = src_sel[LW-1:0];
    mate32   = 32'(f_q) ^ (32'd1 << cur_q);
    mate_ix  = mate32[IW-1:0];
    f_ix     = f_q[IW-1:0];
    split32  = 32'(f_q) + (32'd1 << cur_m1);
  end

  // Reset image of each frame entry during the initialisation sweep.
  always_comb begin
    ic32      = 32'(init_cnt_q);
    init_head = ((ic32 & (32'(Span) - 32'd1)) == 32'd0) &&
                ((ic32 + 32'(Span)) <= 32'(FRAME_COUNT));
    init_mark = init_head ? MW'(TOP_ORDER + 1) : '0;
    init_next = (init_head && (ic32 >= 32'(Span))) ? FW'(ic32 - 32'(Span)) : Nil;
  end

  // Memory port control.
  always_comb begin
    mark_we = 1'b0;
    mark_wa = f_ix;
    mark_wd = '0;
    mark_ra = mate_ix;
    next_we = 1'b0;
    next_wa = f_ix;
    next_wd = head_q[cur_l];
    next_ra = f_ix;
    case (cmd_i.op)
      OP_INIT: begin
        mark_we = 1'b1;
        mark_wa = init_cnt_q;
        mark_wd = init_mark;
        next_we = 1'b1;
        next_wa = init_cnt_q;
        next_wd = init_next;
      end
      OP_ALLOC_RD: begin
        mark_we = 1'b1;
      end
      OP_SPLIT: begin
        mark_we = 1'b1;
        mark_wa = split32[IW-1:0];
        mark_wd = MW'(cur_q);
        next_we = 1'b1;
        next_wa = split32[IW-1:0];
        next_wd = head_q[cur_m1_l];
      end
      OP_WALK_RD: begin
        next_ra = walk_q[IW-1:0];
      end
      OP_WALK_CHK: begin
        if ((32'(walk_q) == mate32) && (prev_q != Nil)) begin
          next_we = 1'b1;
          next_wa = prev_q[IW-1:0];
          next_wd = next_rd_q;
        end
      end
      OP_CLR_F: begin
        mark_we = 1'b1;
      end
      OP_CLR_M: begin
        mark_we = 1'b1;
        mark_wa = mate_ix;
      end
      OP_PUSH: begin
        mark_we = 1'b1;
        mark_wd = MW'(cur_p1);
        next_we = 1'b1;
      end
      default: begin
        mark_we = 1'b0;
      end
    endcase
  end

  // Frame tables with registered reads.
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[next_ra];
  end

  // List heads, sweep counter, pool base and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ListCount; j++) begin
        head_q[j] <= (j == TOP_ORDER) ? FW'(TopHead) : Nil;
      end
      init_cnt_q  <= '0;
      base_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      res_valid_q <= (cmd_i.op == OP_PUSH) || (cmd_i.op == OP_RES_GRANT) ||
                     (cmd_i.op == OP_RES_NOMEM) || (cmd_i.op == OP_RES_ORDER);
      case (cmd_i.op)
        OP_INIT: init_cnt_q <= init_cnt_q + IW'(1);
        OP_ALLOC_POP: head_q[cur_l] <= next_rd_q;
        OP_SPLIT: head_q[cur_m1_l] <= split32[FW-1:0];
        OP_WALK_CHK: begin
          if ((32'(walk_q) == mate32) && (prev_q == Nil)) head_q[cur_l] <= next_rd_q;
        end
        OP_PUSH: head_q[cur_l] <= f_q;
        default: ;
      endcase
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        is_free_q   <= (req_i.req_type == REQ_FREE);
        bad_order_q <= (req_i.block_order > OrderW'(TOP_ORDER));
        lvl_q       <= req_i.block_order;
        found_q     <= src_found;
        out_range_q <= ld_out_range;
        if (req_i.req_type == REQ_FREE) begin
          cur_q <= req_i.block_order;
          f_q   <= fmask[FW-1:0];
        end else begin
          cur_q <= src_sel;
          f_q   <= head_q[src_l];
        end
      end
      OP_SPLIT: cur_q <= cur_m1;
      OP_WALK_START: begin
        walk_q  <= head_q[cur_l];
        prev_q  <= Nil;
        steps_q <= '0;
      end
      OP_WALK_CHK: begin
        if (32'(walk_q) != mate32) begin
          prev_q  <= walk_q;
          walk_q  <= next_rd_q;
          steps_q <= steps_q + SW'(1);
        end
      end
      OP_CLR_M: begin
        f_q   <= f_q & mate32[FW-1:0];
        cur_q <= cur_p1;
      end
      OP_PUSH: begin
        res_q.granted_address <= '0;
        res_q.status          <= STATUS_OK;
      end
      OP_RES_GRANT: begin
        res_q.granted_address <= is_free_q ? 32'd0 : base_q + (32'(f_q) << PAGE_SHIFT);
        res_q.status          <= STATUS_OK;
      end
      OP_RES_NOMEM: begin
        res_q.granted_address <= '0;
        res_q.status          <= STATUS_NO_MEMORY;
      end
      OP_RES_ORDER: begin
        res_q.granted_address <= '0;
        res_q.status          <= STATUS_BAD_ORDER;
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  // Status towards the controller.
  always_comb begin
    status_o.init_last   = (init_cnt_q == IW'(FRAME_COUNT - 1));
    status_o.bad_order   = bad_order_q;
    status_o.is_free     = is_free_q;
    status_o.alloc_found = found_q;
    status_o.out_range   = out_range_q;
    status_o.split_more  = (cur_q > lvl_q);
    status_o.merge_ok    = (cur_q < OrderW'(TOP_ORDER)) && (mate32 < 32'(FRAME_COUNT));
    status_o.mark_match  = (mark_rd_q == MW'(cur_p1));
    status_o.walk_live   = (walk_q < Nil) && (steps_q <= SW'(FRAME_COUNT));
    status_o.walk_hit    = (32'(walk_q) == mate32);
  end

  assign done_o   = res_valid_q;
  assign result_o = res_q;

endmodule

[rtl/core/buddy_page_allocator_unit.sv]
// ---------------------------------------------------------------------------
// Buddy page allocator unit
// Allocates and frees power-of-two blocks of page frames with a buddy scheme.
//
//   channel   transfer when          payload
//   request   start & !busy          req_i (req_type, block_order, block_address)
//   result    done_o                 result_o (granted_address, status)
//   config    cfg_we_i               cfg_wdata_i (pool_base_address)
//
// After reset a sweep loads every entry of the frame tables; busy is
// high meanwhile. An error, an exhausted pool or a free outside the pool
// is answered straight from dispatch. An allocation pops its block from
// the lowest fitting list and then splits it down to the requested order.
// A free merges with its buddy while the buddy's mark matches and the
// buddy is found and unlinked from its list, then pushes the block. The
// frame tables have registered reads. The result is shown for one cycle
// and cannot be stalled.
// ---------------------------------------------------------------------------
module buddy_page_allocator_unit #(
  parameter int unsigned FRAME_COUNT = bpa_pkg::DefFrameCount,
  parameter int unsigned TOP_ORDER   = bpa_pkg::DefTopOrder,
  parameter int unsigned PAGE_SHIFT  = bpa_pkg::DefPageShift
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bpa_pkg::req_t  req_i,
  output logic           done_o,
  output bpa_pkg::res_t  result_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);
  import bpa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  bpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Tables and working registers.
  bpa_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .TOP_ORDER   (TOP_ORDER),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
